### rtl/two_class_lock_arbiter_with_aging_assert.svh
// assertion macros shared by the lock arbiter rtl
// needs a clock and an active-low reset in scope of the caller
`ifndef TWO_CLASS_LOCK_ARBITER_WITH_AGING_ASSERT_SVH
`define TWO_CLASS_LOCK_ARBITER_WITH_AGING_ASSERT_SVH

// same-cycle implication
`define TCLA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lock arbiter check failed");

// next-cycle implication
`define TCLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lock arbiter check failed");

`endif

### rtl/tcla_pkg.sv
// shared types and codes of the two-class lock arbiter
// no dependencies
package tcla_pkg;

	localparam int ID_W   = 4;
	localparam int TIME_W = 32;
	localparam int TMO_W  = 31;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
	localparam logic [OP_W-1:0] OP_ACQUIRE  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_QUEUED    = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_REG   = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_OWNER = 2'd3;

	localparam logic REG_TIMEOUT = 1'b0;

	typedef struct packed {
		logic              cls;
		logic [TIME_W-1:0] stamp;
	} class_entry_t;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [ID_W-1:0]   id;
	} gold_entry_t;

	typedef struct packed {
		logic sel_live;
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} dp_status_t;

endpackage

### rtl/tcla_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tcla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/tcla_ctrl.sv
// controller of the lock arbiter: capture and commit sequencing
// depends on tcla_pkg and the assertion macro header
`include "two_class_lock_arbiter_with_aging_assert.svh"

module tcla_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  tcla_pkg::dp_status_t   dp_status,
	output tcla_pkg::ctrl_cmd_t    cmd
);
	import tcla_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d      = state_q;
		cmd.sel_live = 1'b0;
		cmd.capture  = 1'b0;
		cmd.commit   = 1'b0;
		in_stall     = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall     = 1'b0;
				cmd.sel_live = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!dp_status.out_blocked) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TCLA_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`TCLA_ASSERT_NOW(a_commit_free, clk, arst_n, cmd.commit, !dp_status.out_blocked)
	`TCLA_ASSERT_NEXT(a_commit_idle, clk, arst_n, cmd.commit, !in_stall)

endmodule

### rtl/tcla_dp.sv
// datapath of the lock arbiter: tables, class fifos, owner and result register
// depends on tcla_pkg, tcla_ram and the assertion macro header
`include "two_class_lock_arbiter_with_aging_assert.svh"

module tcla_dp #(
	parameter int MAX_REQUESTERS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcla_pkg::ctrl_cmd_t          cmd,
	output tcla_pkg::dp_status_t         dp_status,
	input  logic [tcla_pkg::OP_W-1:0]    operation,
	input  logic [tcla_pkg::ID_W-1:0]    requester_id,
	input  logic                         requester_class,
	input  logic [tcla_pkg::TIME_W-1:0]  now_time,
	input  logic [tcla_pkg::TMO_W-1:0]   timeout_us,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tcla_pkg::ST_W-1:0]    status,
	output logic                         grant_valid,
	output logic [tcla_pkg::ID_W-1:0]    grant_id,
	output logic                         lock_held
);
	import tcla_pkg::*;

	localparam int IDX_W = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REQUESTERS - 1);

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		r = (p == LAST_IDX) ? '0 : p + 1'b1;
		return r;
	endfunction

	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic              cls_q;
	logic [TIME_W-1:0] now_q;

	logic [MAX_REQUESTERS-1:0] registered_q, registered_d;
	logic [MAX_REQUESTERS-1:0] waiting_q, waiting_d;
	logic [IDX_W-1:0]          g_head_q, g_tail_q, b_head_q, b_tail_q;
	logic [CNT_W-1:0]          g_cnt_q, b_cnt_q;
	logic                      owner_valid_q, owner_valid_d;
	logic [ID_W-1:0]           owner_q, owner_d;

	logic              out_valid_q;
	logic [ST_W-1:0]   status_q, status_d;
	logic              grant_valid_q, grant_valid_d;
	logic [ID_W-1:0]   grant_id_q, grant_id_d;
	logic              lock_held_q;

	class_entry_t      ct_rd, ct_wdata;
	gold_entry_t       g_rd, g_wdata;
	logic [ID_W-1:0]   b_rd;
	logic              ct_we, g_we, b_we, g_pop, b_pop;
	logic [IDX_W-1:0]  ct_raddr, idx;
	logic              in_rng, reg_hit, wait_hit, aged;
	logic [TIME_W-1:0] age;
	logic [ID_W-1:0]   nxt;

	assign ct_raddr = cmd.sel_live ? IDX_W'(requester_id) : IDX_W'(id_q);

	tcla_ram #(.WIDTH($bits(class_entry_t)), .DEPTH(MAX_REQUESTERS)) u_class_ram (
		.clk   (clk),
		.we    (ct_we && cmd.commit),
		.waddr (idx),
		.wdata (ct_wdata),
		.raddr (ct_raddr),
		.rdata (ct_rd)
	);

	tcla_ram #(.WIDTH($bits(gold_entry_t)), .DEPTH(MAX_REQUESTERS)) u_gold_ram (
		.clk   (clk),
		.we    (g_we && cmd.commit),
		.waddr (g_tail_q),
		.wdata (g_wdata),
		.raddr (g_head_q),
		.rdata (g_rd)
	);

	tcla_ram #(.WIDTH(ID_W), .DEPTH(MAX_REQUESTERS)) u_black_ram (
		.clk   (clk),
		.we    (b_we && cmd.commit),
		.waddr (b_tail_q),
		.wdata (id_q),
		.raddr (b_head_q),
		.rdata (b_rd)
	);

	assign idx      = IDX_W'(id_q);
	assign in_rng   = 32'(id_q) < 32'(MAX_REQUESTERS);
	assign reg_hit  = in_rng && registered_q[idx];
	assign wait_hit = in_rng && waiting_q[idx];
	assign age      = now_q - g_rd.stamp;
	assign aged     = age > {1'b0, timeout_us};
	assign ct_wdata = '{cls: cls_q, stamp: now_q};
	assign g_wdata  = '{stamp: ct_rd.stamp, id: id_q};

	always_comb begin
		status_d      = ST_OK;
		grant_valid_d = 1'b0;
		grant_id_d    = '0;
		owner_d       = owner_q;
		owner_valid_d = owner_valid_q;
		registered_d  = registered_q;
		waiting_d     = waiting_q;
		ct_we         = 1'b0;
		g_we          = 1'b0;
		b_we          = 1'b0;
		g_pop         = 1'b0;
		b_pop         = 1'b0;
		nxt           = '0;
		unique case (op_q)
			OP_REGISTER: begin
				if (!in_rng) begin
					status_d = ST_NOT_REG;
				end else if (!wait_hit) begin
					registered_d[idx] = 1'b1;
					ct_we             = 1'b1;
				end
			end
			OP_ACQUIRE: begin
				if (!reg_hit || wait_hit) begin
					status_d = ST_NOT_REG;
				end else if (!owner_valid_q) begin
					owner_valid_d = 1'b1;
					owner_d       = id_q;
					grant_valid_d = 1'b1;
					grant_id_d    = id_q;
				end else begin
					waiting_d[idx] = 1'b1;
					status_d       = ST_QUEUED;
					if (ct_rd.cls) begin
						g_we = 1'b1;
					end else begin
						b_we = 1'b1;
					end
				end
			end
			OP_RELEASE: begin
				if (!in_rng || !owner_valid_q || owner_q != id_q) begin
					status_d = ST_NOT_OWNER;
				end else begin
					if (g_cnt_q != '0 && aged) begin
						g_pop = 1'b1;
					end else if (b_cnt_q != '0) begin
						b_pop = 1'b1;
					end else if (g_cnt_q != '0) begin
						g_pop = 1'b1;
					end
					nxt = g_pop ? g_rd.id : b_rd;
					if (g_pop || b_pop) begin
						waiting_d[IDX_W'(nxt)] = 1'b0;
						owner_d                = nxt;
						grant_valid_d          = 1'b1;
						grant_id_d             = nxt;
					end else begin
						owner_valid_d = 1'b0;
						owner_d       = '0;
					end
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			id_q  <= requester_id;
			cls_q <= requester_class;
			now_q <= now_time;
		end
		if (cmd.commit) begin
			status_q      <= status_d;
			grant_valid_q <= grant_valid_d;
			grant_id_q    <= grant_id_d;
			lock_held_q   <= owner_valid_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			registered_q  <= '0;
			waiting_q     <= '0;
			g_head_q      <= '0;
			g_tail_q      <= '0;
			g_cnt_q       <= '0;
			b_head_q      <= '0;
			b_tail_q      <= '0;
			b_cnt_q       <= '0;
			owner_valid_q <= 1'b0;
			owner_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.commit) begin
				registered_q  <= registered_d;
				waiting_q     <= waiting_d;
				owner_valid_q <= owner_valid_d;
				owner_q       <= owner_d;
				if (g_we) begin
					g_tail_q <= ptr_inc(g_tail_q);
					g_cnt_q  <= g_cnt_q + 1'b1;
				end else if (g_pop) begin
					g_head_q <= ptr_inc(g_head_q);
					g_cnt_q  <= g_cnt_q - 1'b1;
				end
				if (b_we) begin
					b_tail_q <= ptr_inc(b_tail_q);
					b_cnt_q  <= b_cnt_q + 1'b1;
				end else if (b_pop) begin
					b_head_q <= ptr_inc(b_head_q);
					b_cnt_q  <= b_cnt_q - 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dp_status.out_blocked = out_valid_q && out_stall;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign grant_valid = grant_valid_q;
	assign grant_id    = grant_id_q;
	assign lock_held   = lock_held_q;

	`TCLA_ASSERT_NOW(a_wait_count, clk, arst_n, 1'b1,
		$countones(waiting_q) == 32'(g_cnt_q) + 32'(b_cnt_q))
	`TCLA_ASSERT_NOW(a_grant_held, clk, arst_n, out_valid_q && grant_valid_q, lock_held_q)
	`TCLA_ASSERT_NOW(a_owner_free, clk, arst_n, !owner_valid_q, g_cnt_q == '0 && b_cnt_q == '0)

endmodule

### rtl/two_class_lock_arbiter_with_aging.sv
// top level of the two-class lock arbiter: apb timeout register, controller and datapath
// flow: an accepted item is captured into the operand registers while its class entry is read,
// then committed to the tables and the result registers; in_stall holds off the next item
// until that commit, and a waiting result holds the commit back
// reset: owner, fifo pointers, registered and waiting bits clear at once, no clearing pass;
// timeout_us resets to zero, ram contents are not reset
module two_class_lock_arbiter_with_aging #(
	parameter int MAX_REQUESTERS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcla_pkg::ADDR_W-1:0]   paddr,
	input  logic [tcla_pkg::DATA_W-1:0]   pwdata,
	output logic [tcla_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tcla_pkg::OP_W-1:0]     operation,
	input  logic [tcla_pkg::ID_W-1:0]     requester_id,
	input  logic                          requester_class,
	input  logic [tcla_pkg::TIME_W-1:0]   now_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tcla_pkg::ST_W-1:0]     status,
	output logic                          grant_valid,
	output logic [tcla_pkg::ID_W-1:0]     grant_id,
	output logic                          lock_held
);
	import tcla_pkg::*;

	logic [TMO_W-1:0] timeout_q;
	ctrl_cmd_t        cmd;
	dp_status_t       dp_status;
	logic             sel_timeout;

	assign pready      = 1'b1;
	assign sel_timeout = paddr[ADDR_W-1] == REG_TIMEOUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= '0;
		end else if (psel && penable && pwrite && pready && sel_timeout) begin
			timeout_q <= pwdata[TMO_W-1:0];
		end
	end

	assign prdata = sel_timeout ? {{(DATA_W - TMO_W){1'b0}}, timeout_q} : '0;

	tcla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	tcla_dp #(.MAX_REQUESTERS(MAX_REQUESTERS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.dp_status       (dp_status),
		.operation       (operation),
		.requester_id    (requester_id),
		.requester_class (requester_class),
		.now_time        (now_time),
		.timeout_us      (timeout_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.grant_valid     (grant_valid),
		.grant_id        (grant_id),
		.lock_held       (lock_held)
	);

endmodule
